>>> design/pdd_pkg.sv
package pdd_pkg;

    // Fixed field widths
    localparam int DEPTH_W     = 16;
    localparam int COORD_W     = 42;   // normalised coordinate, Q.28, unsaturated
    localparam int SAT_IN_W    = 48;   // common width for saturation
    localparam int DIST_STAGES = 8;    // register stages of the correction pipe
    localparam int Q_FRAC      = 28;
    localparam int DEPTH_SHIFT = 20;

    // Register indexes
    localparam logic [2:0] CFG_MODE     = 3'd0;
    localparam logic [2:0] CFG_CENTRE   = 3'd1;
    localparam logic [2:0] CFG_RFOCAL_X = 3'd2;
    localparam logic [2:0] CFG_RFOCAL_Y = 3'd3;
    localparam logic [2:0] CFG_K1       = 3'd4;
    localparam logic [2:0] CFG_K2       = 3'd5;
    localparam logic [2:0] CFG_K3       = 3'd6;
    localparam logic [2:0] CFG_TANG     = 3'd7;

    localparam logic signed [SAT_IN_W-1:0] S32_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [SAT_IN_W-1:0] S32_MIN = 48'shFFFF_8000_0000;
    localparam logic signed [SAT_IN_W-1:0] Q28_ONE = 48'sh0000_1000_0000;

    typedef struct packed {
        logic [15:0]        pixel_x;
        logic [15:0]        pixel_y;
        logic [DEPTH_W-1:0] depth_mm;
    } pdd_in_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [DEPTH_W-1:0] point_z;
    } pdd_out_t;

    typedef struct packed {
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
    } pdd_coef_t;

    // Travels beside the correction pipe: the raw coordinate for the plain pinhole path and the depth
    typedef struct packed {
        logic signed [COORD_W-1:0] x_raw;
        logic signed [COORD_W-1:0] y_raw;
        logic [DEPTH_W-1:0]        depth;
    } pdd_carry_t;

    function automatic logic signed [31:0] sat32(input logic signed [SAT_IN_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q4.28 product, floored, saturated
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic signed [63:0] s;
        p = 64'(a) * 64'(b);
        s = p >>> Q_FRAC;
        return sat32(s[SAT_IN_W-1:0]);
    endfunction

endpackage

>>> design/pixel_depth_deproject_unit.sv
// Pixel-to-point deprojection. Each item is a pixel position (Q12.4) and
// its depth in millimetres; the block returns the camera-space point with X
// and Y in 1/256 mm (saturated to 32 bits) and Z equal to the depth. One
// item is taken every clock: busy never rises. Every item comes out in
// order, with done high for a single cycle; the result ports must be
// sampled then, as there is no stall from the receiving side. The pipe
// runs through centring and the reciprocal focal multiply, then the
// radial and tangential correction multiplier chain, then the depth
// scaling and saturation. The plain pinhole mode takes the same path
// and latency. Load the registers only while the pipe is empty (no
// item in the last 12 cycles).
module pixel_depth_deproject_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  pdd_pkg::pdd_in_t  pixel,
    output logic              done,
    output pdd_pkg::pdd_out_t point,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [63:0]       cfg_data
);
    import pdd_pkg::*;

    localparam int LATENCY = DIST_STAGES + 4;
    localparam int PT_W    = COORD_W + DEPTH_W + 1;

    // Configuration registers
    logic        mode_reg;
    logic [31:0] centre_reg;
    logic [31:0] rfx_reg;
    logic [31:0] rfy_reg;
    logic [31:0] k1_reg;
    logic [31:0] k2_reg;
    logic [31:0] k3_reg;
    logic [63:0] tang_reg;
    pdd_coef_t   coef;

    // Stage 1: centred pixel times reciprocal focal length
    logic                     v1_reg;
    logic signed [49:0]       prodx_reg, prody_reg;
    logic [DEPTH_W-1:0]       depth1_reg;
    logic signed [16:0]       dx_next, dy_next;

    // Stage 2: normalised coordinate, Q.28
    logic                     v2_reg;
    pdd_carry_t               car2_reg;
    logic signed [31:0]       xs2_reg, ys2_reg;
    logic signed [COORD_W-1:0] x_next, y_next;

    // Correction pipe outputs
    logic                     vd;
    logic signed [31:0]       xd, yd;
    pdd_carry_t               card;
    logic signed [COORD_W-1:0] cx_next, cy_next;

    // Stage 11: depth products
    logic                     v11_reg;
    logic signed [COORD_W+DEPTH_W:0] ptx_reg, pty_reg;
    logic [DEPTH_W-1:0]       depth11_reg;

    // Stage 12: output register
    logic                     done_reg;
    pdd_out_t                 point_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            centre_reg <= '0;
            rfx_reg    <= '0;
            rfy_reg    <= '0;
            k1_reg     <= '0;
            k2_reg     <= '0;
            k3_reg     <= '0;
            tang_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:     mode_reg   <= cfg_data[0];
                CFG_CENTRE:   centre_reg <= cfg_data[31:0];
                CFG_RFOCAL_X: rfx_reg    <= cfg_data[31:0];
                CFG_RFOCAL_Y: rfy_reg    <= cfg_data[31:0];
                CFG_K1:       k1_reg     <= cfg_data[31:0];
                CFG_K2:       k2_reg     <= cfg_data[31:0];
                CFG_K3:       k3_reg     <= cfg_data[31:0];
                CFG_TANG:     tang_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign coef.k1 = $signed(k1_reg);
    assign coef.k2 = $signed(k2_reg);
    assign coef.k3 = $signed(k3_reg);
    assign coef.p1 = $signed(tang_reg[31:0]);
    assign coef.p2 = $signed(tang_reg[63:32]);

    // Centre the pixel on the principal point (17-bit signed difference)
    assign dx_next = $signed({1'b0, pixel.pixel_x}) - $signed({1'b0, centre_reg[15:0]});
    assign dy_next = $signed({1'b0, pixel.pixel_y}) - $signed({1'b0, centre_reg[31:16]});

    // Drop eight fraction bits: Q.36 product becomes Q.28, floored
    assign x_next = $signed(prodx_reg[49:8]);
    assign y_next = $signed(prody_reg[49:8]);

    // Pick the corrected or the plain coordinate
    assign cx_next = mode_reg ? COORD_W'(xd) : card.x_raw;
    assign cy_next = mode_reg ? COORD_W'(yd) : card.y_raw;

    // Valid line; payload registers carry no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v11_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v11_reg  <= vd;
            done_reg <= v11_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prodx_reg  <= 50'(dx_next) * 50'($signed({1'b0, rfx_reg}));
        prody_reg  <= 50'(dy_next) * 50'($signed({1'b0, rfy_reg}));
        depth1_reg <= pixel.depth_mm;

        car2_reg.x_raw <= x_next;
        car2_reg.y_raw <= y_next;
        car2_reg.depth <= depth1_reg;
        xs2_reg        <= sat32(SAT_IN_W'(x_next));
        ys2_reg        <= sat32(SAT_IN_W'(y_next));

        ptx_reg     <= PT_W'($signed({1'b0, card.depth})) * PT_W'(cx_next);
        pty_reg     <= PT_W'($signed({1'b0, card.depth})) * PT_W'(cy_next);
        depth11_reg <= card.depth;

        // Arithmetic shift floors, then saturate to 32 bits
        point_reg.point_x <= sat32(SAT_IN_W'($signed(ptx_reg[COORD_W+DEPTH_W:DEPTH_SHIFT])));
        point_reg.point_y <= sat32(SAT_IN_W'($signed(pty_reg[COORD_W+DEPTH_W:DEPTH_SHIFT])));
        point_reg.point_z <= depth11_reg;
    end

    pdd_distort u_distort (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .in_valid  (v2_reg),
        .xs        (xs2_reg),
        .ys        (ys2_reg),
        .carry_in  (car2_reg),
        .out_valid (vd),
        .xd        (xd),
        .yd        (yd),
        .carry_out (card)
    );

    assign done  = done_reg;
    assign point = point_reg;

`ifndef SYNTHESIS
    // Every accepted item leaves after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item did not complete after pipeline latency");

    // No result without an accepted item
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    // Z follows the depth of the accepted item that the result belongs to
    a_depth_carry: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> point.point_z == $past(pixel.depth_mm, LATENCY))
        else $error("depth misaligned with its point");

    // Zero depth gives the origin
    a_zero_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (done && point.point_z == '0) |-> (point.point_x == 0 && point.point_y == 0))
        else $error("zero depth gave a non-zero point");
`endif

endmodule

>>> design/pdd_distort.sv
module pdd_distort (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pdd_pkg::pdd_coef_t   coef,
    input  logic                 in_valid,
    input  logic signed [31:0]   xs,
    input  logic signed [31:0]   ys,
    input  pdd_pkg::pdd_carry_t  carry_in,
    output logic                 out_valid,
    output logic signed [31:0]   xd,
    output logic signed [31:0]   yd,
    output pdd_pkg::pdd_carry_t  carry_out
);
    import pdd_pkg::*;

    logic [DIST_STAGES-1:0] vld_reg;
    pdd_carry_t             car_reg [DIST_STAGES];

    // stage 1
    logic signed [31:0] xx1_reg, yy1_reg, xy1_reg, xs1_reg, ys1_reg;
    // stage 2
    logic signed [31:0] r2_2_reg, xx2_reg, yy2_reg, xy2_reg, xs2_reg, ys2_reg;
    logic signed [31:0] r2_next;
    // stage 3
    logic signed [31:0] r4_3_reg, a2x3_reg, a2y3_reg, k1r2_3_reg, pxy1_3_reg, pxy2_3_reg;
    logic signed [31:0] r2_3_reg, xs3_reg, ys3_reg;
    logic signed [31:0] a2x_next, a2y_next;
    // stage 4
    logic signed [31:0] r6_4_reg, k2r4_4_reg, tx2_4_reg, ty1_4_reg;
    logic signed [31:0] k1r2_4_reg, pxy1_4_reg, pxy2_4_reg, xs4_reg, ys4_reg;
    // stage 5
    logic signed [31:0] k3r6_5_reg, k1r2_5_reg, k2r4_5_reg, tx2_5_reg, ty1_5_reg;
    logic signed [31:0] pxy1_5_reg, pxy2_5_reg, xs5_reg, ys5_reg;
    // stage 6
    logic signed [31:0] f6_reg, tx2_6_reg, ty1_6_reg, pxy1_6_reg, pxy2_6_reg;
    logic signed [31:0] xs6_reg, ys6_reg;
    logic signed [31:0] f_next;
    // stage 7
    logic signed [31:0] mx7_reg, my7_reg, tx2_7_reg, ty1_7_reg, pxy1_7_reg, pxy2_7_reg;
    // stage 8
    logic signed [31:0] xd8_reg, yd8_reg;
    logic signed [31:0] xd_next, yd_next;

    assign r2_next  = sat32(SAT_IN_W'(xx1_reg) + SAT_IN_W'(yy1_reg));
    assign a2x_next = sat32(SAT_IN_W'(r2_2_reg) + (SAT_IN_W'(xx2_reg) <<< 1));
    assign a2y_next = sat32(SAT_IN_W'(r2_2_reg) + (SAT_IN_W'(yy2_reg) <<< 1));
    assign f_next   = sat32(Q28_ONE + SAT_IN_W'(k1r2_5_reg) + SAT_IN_W'(k2r4_5_reg)
                            + SAT_IN_W'(k3r6_5_reg));
    assign xd_next  = sat32(SAT_IN_W'(mx7_reg) + (SAT_IN_W'(pxy1_7_reg) <<< 1)
                            + SAT_IN_W'(tx2_7_reg));
    assign yd_next  = sat32(SAT_IN_W'(my7_reg) + (SAT_IN_W'(pxy2_7_reg) <<< 1)
                            + SAT_IN_W'(ty1_7_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DIST_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        car_reg[0] <= carry_in;
        for (int i = 1; i < DIST_STAGES; i++)
        begin
            car_reg[i] <= car_reg[i-1];
        end

        xx1_reg <= mulq(xs, xs);
        yy1_reg <= mulq(ys, ys);
        xy1_reg <= mulq(xs, ys);
        xs1_reg <= xs;
        ys1_reg <= ys;

        r2_2_reg <= r2_next;
        xx2_reg  <= xx1_reg;
        yy2_reg  <= yy1_reg;
        xy2_reg  <= xy1_reg;
        xs2_reg  <= xs1_reg;
        ys2_reg  <= ys1_reg;

        r4_3_reg   <= mulq(r2_2_reg, r2_2_reg);
        a2x3_reg   <= a2x_next;
        a2y3_reg   <= a2y_next;
        k1r2_3_reg <= mulq(coef.k1, r2_2_reg);
        pxy1_3_reg <= mulq(coef.p1, xy2_reg);
        pxy2_3_reg <= mulq(coef.p2, xy2_reg);
        r2_3_reg   <= r2_2_reg;
        xs3_reg    <= xs2_reg;
        ys3_reg    <= ys2_reg;

        r6_4_reg   <= mulq(r4_3_reg, r2_3_reg);
        k2r4_4_reg <= mulq(coef.k2, r4_3_reg);
        tx2_4_reg  <= mulq(coef.p2, a2x3_reg);
        ty1_4_reg  <= mulq(coef.p1, a2y3_reg);
        k1r2_4_reg <= k1r2_3_reg;
        pxy1_4_reg <= pxy1_3_reg;
        pxy2_4_reg <= pxy2_3_reg;
        xs4_reg    <= xs3_reg;
        ys4_reg    <= ys3_reg;

        k3r6_5_reg <= mulq(coef.k3, r6_4_reg);
        k1r2_5_reg <= k1r2_4_reg;
        k2r4_5_reg <= k2r4_4_reg;
        tx2_5_reg  <= tx2_4_reg;
        ty1_5_reg  <= ty1_4_reg;
        pxy1_5_reg <= pxy1_4_reg;
        pxy2_5_reg <= pxy2_4_reg;
        xs5_reg    <= xs4_reg;
        ys5_reg    <= ys4_reg;

        f6_reg     <= f_next;
        tx2_6_reg  <= tx2_5_reg;
        ty1_6_reg  <= ty1_5_reg;
        pxy1_6_reg <= pxy1_5_reg;
        pxy2_6_reg <= pxy2_5_reg;
        xs6_reg    <= xs5_reg;
        ys6_reg    <= ys5_reg;

        mx7_reg    <= mulq(xs6_reg, f6_reg);
        my7_reg    <= mulq(ys6_reg, f6_reg);
        tx2_7_reg  <= tx2_6_reg;
        ty1_7_reg  <= ty1_6_reg;
        pxy1_7_reg <= pxy1_6_reg;
        pxy2_7_reg <= pxy2_6_reg;

        xd8_reg <= xd_next;
        yd8_reg <= yd_next;
    end

    assign out_valid = vld_reg[DIST_STAGES-1];
    assign xd        = xd8_reg;
    assign yd        = yd8_reg;
    assign carry_out = car_reg[DIST_STAGES-1];

endmodule
